FILE: design/mfz_pkg.sv
// Package for the zero-padded median filter.
// Holds the pixel type, register indexes and register reset values.
// No dependencies.
package mfz_pkg;

    localparam int PIXEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_IMAGE_HEIGHT = 2'd1;

    localparam int RESET_IMAGE_WIDTH  = 1024;
    localparam int RESET_IMAGE_HEIGHT = 1024;

endpackage

FILE: design/mfz_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// No dependencies.
module mfz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/median_filter_window_zero_pad_top.sv
// Zero-padded square-window median filter, top level; uses mfz_pkg and mfz_ram.
// One pixel per cycle is taken unless the output stalls; the window of a pixel completes
// pad rows plus pad pixels later, and its result is registered in s1, s2, s3 and out.
// The line store is one RAM word per column holding the previous KERNEL_SIZE-1 rows.
// Reset is synchronous: counters go to zero and the dimensions to 1024 (capped at the
// maximum); the line store is not cleared, since taps outside the image read as zero.
module median_filter_window_zero_pad_top
    import mfz_pkg::*;
#(
    parameter int KERNEL_SIZE = 5,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  t_cfg_data i_cfg_data,
    input  logic      i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] pixel
    output logic      o_m_axis_tvalid,
    input  logic      i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] median
    output logic      o_m_axis_tlast     // frame_last
);

    localparam int K     = KERNEL_SIZE;
    localparam int PAD   = K / 2;
    localparam int TAPS  = K * K;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + PAD * MAX_WIDTH + PAD);
    localparam int RKW   = $clog2(TAPS);
    localparam int LW    = PIXEL_W * (K - 1);
    localparam int RMW   = HW + 1;
    localparam int CMW   = WW + 1;
    localparam int RST_W = (RESET_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_IMAGE_WIDTH;
    localparam int RST_H = (RESET_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_IMAGE_HEIGHT;

    // Frame geometry.
    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [NW-1:0] r_lag, n_lag;
    logic [NW-1:0] r_n_last, n_n_last;
    logic          cfg_hit;

    // Position counters.
    logic [NW-1:0] r_n;
    logic [CW-1:0] r_in_col;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    // Pipeline control.
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic in_fire, s1_fire;
    logic produce, restart;

    // Stage payloads.
    t_pixel         r_s1_pix;
    logic [CW-1:0]  r_s1_addr;
    logic           r_s1_prod;
    logic           r_s1_last;
    logic [K-1:0]   r_s1_rmask, r_s1_cmask;
    logic           r_s1_byp;
    logic [LW-1:0]  r_s1_bypdata;
    logic [LW-1:0]  ram_rdata, stack_word, new_word;
    logic [K-1:0]   rmask, cmask;

    t_pixel         r_win [K][K];
    logic           r_s2_last;
    logic [K-1:0]   r_s2_rmask, r_s2_cmask;
    t_pixel         s2_tap [TAPS];
    logic [TAPS-1:0] s2_lt [TAPS];

    t_pixel         r_s3_tap [TAPS];
    logic [TAPS-1:0] r_s3_lt [TAPS];
    logic           r_s3_last;
    logic [TAPS-1:0] s3_sel;
    t_pixel         s3_med;

    t_pixel         r_out_med;
    logic           r_out_last;

    function automatic logic [WW-1:0] eff_width(input t_cfg_data raw);
        logic [WW-1:0] v;
        if (raw == '0) begin
            v = WW'(1);
        end else if (32'(raw) > MAX_WIDTH) begin
            v = WW'(MAX_WIDTH);
        end else begin
            v = WW'(raw);
        end
        return v;
    endfunction

    function automatic logic [HW-1:0] eff_height(input t_cfg_data raw);
        logic [HW-1:0] v;
        if (raw == '0) begin
            v = HW'(1);
        end else if (32'(raw) > MAX_HEIGHT) begin
            v = HW'(MAX_HEIGHT);
        end else begin
            v = HW'(raw);
        end
        return v;
    endfunction

    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (i_cfg_we && i_cfg_idx == REG_IMAGE_WIDTH) begin
            n_w = eff_width(i_cfg_data);
        end
        if (i_cfg_we && i_cfg_idx == REG_IMAGE_HEIGHT) begin
            n_h = eff_height(i_cfg_data);
        end
        cfg_hit  = i_cfg_we && (i_cfg_idx == REG_IMAGE_WIDTH || i_cfg_idx == REG_IMAGE_HEIGHT);
        n_lag    = NW'(PAD) * NW'(n_w) + NW'(PAD);
        n_n_last = NW'(n_w) * NW'(n_h) + n_lag - NW'(1);
    end

    assign out_rdy = !r_out_v || i_m_axis_tready;
    assign s3_rdy  = !r_s3_v || out_rdy;
    assign s2_rdy  = !r_s2_v || s3_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign in_fire = i_s_axis_tvalid && s1_rdy;
    assign s1_fire = r_s1_v && s2_rdy;
    assign produce = r_n >= r_lag;
    assign restart = r_n == r_n_last;

    always_comb begin
        for (int jr = 0; jr < K; jr++) begin
            rmask[jr] = (RMW'(r_out_row) + RMW'(jr) >= RMW'(PAD))
                     && (RMW'(r_out_row) + RMW'(jr) < RMW'(r_h) + RMW'(PAD));
        end
        for (int jc = 0; jc < K; jc++) begin
            cmask[jc] = (CMW'(r_out_col) + CMW'(jc) >= CMW'(PAD))
                     && (CMW'(r_out_col) + CMW'(jc) < CMW'(r_w) + CMW'(PAD));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WW'(RST_W);
            r_h       <= HW'(RST_H);
            r_lag     <= NW'(PAD * RST_W + PAD);
            r_n_last  <= NW'(RST_W * RST_H + PAD * RST_W + PAD - 1);
            r_n       <= '0;
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (cfg_hit) begin
                r_w       <= n_w;
                r_h       <= n_h;
                r_lag     <= n_lag;
                r_n_last  <= n_n_last;
                r_n       <= '0;
                r_in_col  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (in_fire) begin
                if (restart) begin
                    r_n       <= '0;
                    r_in_col  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else begin
                    r_n <= r_n + NW'(1);
                    if (WW'(r_in_col) + WW'(1) == r_w) begin
                        r_in_col <= '0;
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                    if (produce) begin
                        if (WW'(r_out_col) + WW'(1) == r_w) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + RW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
            end
            if (s1_rdy) begin
                r_s1_v <= i_s_axis_tvalid;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v && r_s1_prod;
            end
            if (s3_rdy) begin
                r_s3_v <= r_s2_v;
            end
            if (out_rdy) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    mfz_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata (new_word),
        .i_re    (in_fire),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    // The newest row enters the lowest slot and the oldest row drops out of the top.
    assign stack_word = r_s1_byp ? r_s1_bypdata : ram_rdata;
    assign new_word   = {stack_word[LW-PIXEL_W-1:0], r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix     <= i_s_axis_tdata;
            r_s1_addr    <= r_in_col;
            r_s1_prod    <= produce;
            r_s1_last    <= restart;
            r_s1_rmask   <= rmask;
            r_s1_cmask   <= cmask;
            r_s1_byp     <= s1_fire && (r_s1_addr == r_in_col);
            r_s1_bypdata <= new_word;
        end
        if (s1_fire) begin
            for (int jc = 0; jc < K - 1; jc++) begin
                for (int jr = 0; jr < K; jr++) begin
                    r_win[jc][jr] <= r_win[jc+1][jr];
                end
            end
            r_win[K-1][K-1] <= r_s1_pix;
            for (int s = 0; s < K - 1; s++) begin
                r_win[K-1][K-2-s] <= stack_word[s*PIXEL_W +: PIXEL_W];
            end
            r_s2_last  <= r_s1_last;
            r_s2_rmask <= r_s1_rmask;
            r_s2_cmask <= r_s1_cmask;
        end
    end

    // Each tap is ranked against all others; equal values are ordered by tap index.
    always_comb begin
        for (int jr = 0; jr < K; jr++) begin
            for (int jc = 0; jc < K; jc++) begin
                s2_tap[jr*K+jc] = (r_s2_rmask[jr] && r_s2_cmask[jc]) ? r_win[jc][jr] : '0;
            end
        end
        for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
                s2_lt[i][j] = (s2_tap[j] < s2_tap[i]) || (s2_tap[j] == s2_tap[i] && j < i);
            end
        end
    end

    always_comb begin
        s3_med = '0;
        for (int i = 0; i < TAPS; i++) begin
            s3_sel[i] = RKW'($countones(r_s3_lt[i])) == RKW'(TAPS / 2);
            s3_med    = s3_med | (s3_sel[i] ? r_s3_tap[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && s3_rdy) begin
            r_s3_tap  <= s2_tap;
            r_s3_lt   <= s2_lt;
            r_s3_last <= r_s2_last;
        end
        if (r_s3_v && out_rdy) begin
            r_out_med  <= s3_med;
            r_out_last <= r_s3_last;
        end
    end

    assign o_s_axis_tready = s1_rdy;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_med;
    assign o_m_axis_tlast  = r_out_last;

    a_rank_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> $onehot(s3_sel))
        else $error("median rank select is not one-hot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= r_n_last)
        else $error("item counter ran past the end of the frame");

    a_in_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_w)
        else $error("input column outside the image width");

    a_out_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_out_col) < r_w)
        else $error("output column outside the image width");

    a_last_produces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !cfg_hit && restart) |-> produce)
        else $error("frame end reached on an item that gives no result");

endmodule
